// File: hdl/cfp_pkg.sv
// Shared types, widths and status codes for the circle-from-three-points block.
// Used by cfp_div_cell, cfp_sqrt_cell and circle_from_three_points.
package cfp_pkg;

  localparam int COORD_W  = 16;  // input coordinate
  localparam int DIFF_W   = 17;  // difference of two coordinates
  localparam int PROD_W   = 34;  // product of two differences, determinant
  localparam int SQ_W     = 34;  // squared length of a difference vector
  localparam int NUM_W    = 52;  // numerator, magnitude of quotient
  localparam int DEN_W    = 34;  // magnitude of twice the determinant
  localparam int REM_W    = DEN_W + 1;
  localparam int OFF_W    = NUM_W + 1;
  localparam int OUT_W    = 32;
  localparam int CTR_W    = OUT_W + 2;
  localparam int R2_W     = 2 * OUT_W;
  localparam int DIV_STEPS  = NUM_W;
  localparam int SQRT_STEPS = OUT_W;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_COLLINEAR = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  // Two restoring dividers running side by side on one shared divisor.
  typedef struct packed {
    logic [REM_W-1:0]          rem_x;
    logic [REM_W-1:0]          rem_y;
    logic [NUM_W-1:0]          nq_x;   // numerator bits out, quotient bits in
    logic [NUM_W-1:0]          nq_y;
    logic [DEN_W-1:0]          den;
    logic                      neg_x;
    logic                      neg_y;
    logic                      coll;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
  } div_t;

  typedef struct packed {
    logic [R2_W-1:0]          n;
    logic [R2_W-1:0]          root;
    status_e                  status;
    logic signed [OUT_W-1:0]  cx;
    logic signed [OUT_W-1:0]  cy;
  } sq_t;

  typedef struct packed {
    status_e                  status;
    logic signed [OUT_W-1:0]  cx;
    logic signed [OUT_W-1:0]  cy;
    logic [OUT_W-1:0]         radius;
  } res_t;

endpackage

// File: hdl/cfp_div_cell.sv
// One restoring-division step for the x and y quotients, sharing one divisor.
// Depends on cfp_pkg for div_t and the widths.
module cfp_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cfp_pkg::div_t data_i,
  output logic          valid_o,
  output cfp_pkg::div_t data_o
);

  logic                        valid_q;
  cfp_pkg::div_t               data_d, data_q;
  logic [cfp_pkg::REM_W-1:0]   sh_x, sh_y, dv;
  logic                        ge_x, ge_y;

  always_comb begin
    dv   = {1'b0, data_i.den};
    sh_x = {data_i.rem_x[cfp_pkg::REM_W-2:0], data_i.nq_x[cfp_pkg::NUM_W-1]};
    sh_y = {data_i.rem_y[cfp_pkg::REM_W-2:0], data_i.nq_y[cfp_pkg::NUM_W-1]};
    ge_x = sh_x >= dv;
    ge_y = sh_y >= dv;
    data_d       = data_i;
    data_d.rem_x = ge_x ? sh_x - dv : sh_x;
    data_d.rem_y = ge_y ? sh_y - dv : sh_y;
    data_d.nq_x  = {data_i.nq_x[cfp_pkg::NUM_W-2:0], ge_x};
    data_d.nq_y  = {data_i.nq_y[cfp_pkg::NUM_W-2:0], ge_y};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hdl/cfp_sqrt_cell.sv
// One step of the digit-by-digit integer square root; wt_i is the step's power of four.
// Depends on cfp_pkg for sq_t and the widths.
module cfp_sqrt_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [cfp_pkg::R2_W-1:0]   wt_i,
  input  logic                       valid_i,
  input  cfp_pkg::sq_t               data_i,
  output logic                       valid_o,
  output cfp_pkg::sq_t               data_o
);

  logic                      valid_q;
  cfp_pkg::sq_t              data_d, data_q;
  logic [cfp_pkg::R2_W-1:0]  trial;
  logic                      ge;

  always_comb begin
    trial  = data_i.root + wt_i;
    ge     = data_i.n >= trial;
    data_d = data_i;
    data_d.n    = ge ? data_i.n - trial : data_i.n;
    data_d.root = ge ? (data_i.root >> 1) + wt_i : data_i.root >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hdl/circle_from_three_points.sv
// Top level of the circle-from-three-points block: front arithmetic, the divider
// and square-root cell chains, and the output register with skid stage.
// Depends on cfp_pkg, cfp_div_cell and cfp_sqrt_cell.
//
// Usage: an input transfer carries three points with signed 16-bit coordinates.
// For each one the block returns exactly one result transfer with the status
// (circle found, collinear, or out of range), the center and the floor of the
// radius. Results leave in the order the points arrived.
// Throughput is one item per cycle while the receiver takes results. From input
// transfer to output valid the path runs through six stages of differences,
// products and numerators, a chain of 52 division cells (one quotient bit
// each), four stages of range checks and squares, a chain of 32 square-root
// cells (one root bit each) and the output register.
// When the receiver stalls, the pipeline keeps moving until one more result has
// landed in the skid stage; then in_ready_o drops and the whole pipeline holds.
// in_ready_o comes straight from a register. Reset clears all valid bits and
// leaves the block empty and ready; no clearing pass is needed.
module circle_from_three_points (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [cfp_pkg::COORD_W-1:0]    first_x_i,
  input  logic signed [cfp_pkg::COORD_W-1:0]    first_y_i,
  input  logic signed [cfp_pkg::COORD_W-1:0]    second_x_i,
  input  logic signed [cfp_pkg::COORD_W-1:0]    second_y_i,
  input  logic signed [cfp_pkg::COORD_W-1:0]    third_x_i,
  input  logic signed [cfp_pkg::COORD_W-1:0]    third_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            status_o,
  output logic signed [cfp_pkg::OUT_W-1:0]      center_x_o,
  output logic signed [cfp_pkg::OUT_W-1:0]      center_y_o,
  output logic [cfp_pkg::OUT_W-1:0]             radius_o
);

  localparam int FRONT = 6;
  localparam int BACK  = 4;

  // The whole pipeline advances together unless the skid stage is occupied.
  logic en;
  logic skid_valid_q, out_valid_q;
  cfp_pkg::res_t skid_q, out_q;

  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  logic [FRONT-1:0] fv_q;
  logic [BACK-1:0]  bv_q;

  // Stage 1: differences from the first point.
  logic signed [cfp_pkg::DIFF_W-1:0]  dx2_q, dy2_q, dx3_q, dy3_q;
  logic signed [cfp_pkg::COORD_W-1:0] ax1_q, ay1_q;
  // Stage 2: products.
  logic signed [cfp_pkg::PROD_W-1:0]  pa_q, pb_q, sx2_q, sy2_q, sx3_q, sy3_q;
  logic signed [cfp_pkg::DIFF_W-1:0]  dx2b_q, dy2b_q, dx3b_q, dy3b_q;
  logic signed [cfp_pkg::COORD_W-1:0] ax2_q, ay2_q;
  // Stage 3: determinant and squared lengths.
  logic signed [cfp_pkg::PROD_W-1:0]  det3_q;
  logic [cfp_pkg::SQ_W-1:0]           sq2_q, sq3_q;
  logic signed [cfp_pkg::DIFF_W-1:0]  dx2c_q, dy2c_q, dx3c_q, dy3c_q;
  logic signed [cfp_pkg::COORD_W-1:0] ax3_q, ay3_q;
  // Stage 4: numerator products.
  logic signed [cfp_pkg::NUM_W-1:0]   m1_q, m2_q, m3_q, m4_q;
  logic signed [cfp_pkg::PROD_W-1:0]  det4_q;
  logic signed [cfp_pkg::COORD_W-1:0] ax4_q, ay4_q;
  // Stage 5: numerators and divisor magnitude.
  logic signed [cfp_pkg::NUM_W-1:0]   numx_q, numy_q;
  logic [cfp_pkg::DEN_W-1:0]          den_q;
  logic                               detneg_q, coll_q;
  logic signed [cfp_pkg::COORD_W-1:0] ax5_q, ay5_q;
  // Stage 6 is the divider chain's input.
  cfp_pkg::div_t                      div_in_q;

  logic [cfp_pkg::PROD_W-1:0]         det_abs;

  always_comb begin
    det_abs = det4_q[cfp_pkg::PROD_W-1] ? cfp_pkg::PROD_W'(-det4_q)
                                        : cfp_pkg::PROD_W'(det4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (en) begin
      fv_q <= {fv_q[FRONT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx2_q <= cfp_pkg::DIFF_W'(second_x_i) - cfp_pkg::DIFF_W'(first_x_i);
      dy2_q <= cfp_pkg::DIFF_W'(second_y_i) - cfp_pkg::DIFF_W'(first_y_i);
      dx3_q <= cfp_pkg::DIFF_W'(third_x_i) - cfp_pkg::DIFF_W'(first_x_i);
      dy3_q <= cfp_pkg::DIFF_W'(third_y_i) - cfp_pkg::DIFF_W'(first_y_i);
      ax1_q <= first_x_i;
      ay1_q <= first_y_i;

      pa_q  <= cfp_pkg::PROD_W'(dy3_q) * cfp_pkg::PROD_W'(dx2_q);
      pb_q  <= cfp_pkg::PROD_W'(dx3_q) * cfp_pkg::PROD_W'(dy2_q);
      sx2_q <= cfp_pkg::PROD_W'(dx2_q) * cfp_pkg::PROD_W'(dx2_q);
      sy2_q <= cfp_pkg::PROD_W'(dy2_q) * cfp_pkg::PROD_W'(dy2_q);
      sx3_q <= cfp_pkg::PROD_W'(dx3_q) * cfp_pkg::PROD_W'(dx3_q);
      sy3_q <= cfp_pkg::PROD_W'(dy3_q) * cfp_pkg::PROD_W'(dy3_q);
      dx2b_q <= dx2_q;
      dy2b_q <= dy2_q;
      dx3b_q <= dx3_q;
      dy3b_q <= dy3_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;

      det3_q <= pa_q - pb_q;
      sq2_q  <= cfp_pkg::SQ_W'(sx2_q) + cfp_pkg::SQ_W'(sy2_q);
      sq3_q  <= cfp_pkg::SQ_W'(sx3_q) + cfp_pkg::SQ_W'(sy3_q);
      dx2c_q <= dx2b_q;
      dy2c_q <= dy2b_q;
      dx3c_q <= dx3b_q;
      dy3c_q <= dy3b_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;

      m1_q <= cfp_pkg::NUM_W'($signed({1'b0, sq2_q})) * cfp_pkg::NUM_W'(dy3c_q);
      m2_q <= cfp_pkg::NUM_W'($signed({1'b0, sq3_q})) * cfp_pkg::NUM_W'(dy2c_q);
      m3_q <= cfp_pkg::NUM_W'($signed({1'b0, sq3_q})) * cfp_pkg::NUM_W'(dx2c_q);
      m4_q <= cfp_pkg::NUM_W'($signed({1'b0, sq2_q})) * cfp_pkg::NUM_W'(dx3c_q);
      det4_q <= det3_q;
      ax4_q  <= ax3_q;
      ay4_q  <= ay3_q;

      numx_q   <= m1_q - m2_q;
      numy_q   <= m3_q - m4_q;
      den_q    <= {det_abs[cfp_pkg::DEN_W-2:0], 1'b0};
      detneg_q <= det4_q[cfp_pkg::PROD_W-1];
      coll_q   <= (det4_q == '0);
      ax5_q    <= ax4_q;
      ay5_q    <= ay4_q;

      div_in_q.rem_x <= '0;
      div_in_q.rem_y <= '0;
      div_in_q.nq_x  <= numx_q[cfp_pkg::NUM_W-1] ? cfp_pkg::NUM_W'(-numx_q)
                                                 : cfp_pkg::NUM_W'(numx_q);
      div_in_q.nq_y  <= numy_q[cfp_pkg::NUM_W-1] ? cfp_pkg::NUM_W'(-numy_q)
                                                 : cfp_pkg::NUM_W'(numy_q);
      div_in_q.den   <= den_q;
      div_in_q.neg_x <= numx_q[cfp_pkg::NUM_W-1] ^ detneg_q;
      div_in_q.neg_y <= numy_q[cfp_pkg::NUM_W-1] ^ detneg_q;
      div_in_q.coll  <= coll_q;
      div_in_q.ax    <= ax5_q;
      div_in_q.ay    <= ay5_q;
    end
  end

  // Divider chain: one quotient bit per cell, most significant first.
  logic          div_v [cfp_pkg::DIV_STEPS+1];
  cfp_pkg::div_t div_d [cfp_pkg::DIV_STEPS+1];

  assign div_v[0] = fv_q[FRONT-1];
  assign div_d[0] = div_in_q;

  for (genvar i = 0; i < cfp_pkg::DIV_STEPS; i++) begin : g_div
    cfp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_v[i]),
      .data_i  (div_d[i]),
      .valid_o (div_v[i+1]),
      .data_o  (div_d[i+1])
    );
  end

  cfp_pkg::div_t dq;
  assign dq = div_d[cfp_pkg::DIV_STEPS];

  // Back stages: signed offsets, range checks, center, squared radius.
  logic signed [cfp_pkg::OFF_W-1:0]   offx_q, offy_q;
  logic                               collb_q, collc_q;
  logic signed [cfp_pkg::COORD_W-1:0] axb_q, ayb_q;
  logic                               fitx_q, fity_q;
  logic signed [cfp_pkg::CTR_W-1:0]   ctrx_q, ctry_q;
  logic [cfp_pkg::OUT_W-1:0]          magx_q, magy_q;
  cfp_pkg::status_e                   st_q;
  logic signed [cfp_pkg::OUT_W-1:0]   cx_q, cy_q;
  logic [cfp_pkg::R2_W-1:0]           r2x_q, r2y_q;
  cfp_pkg::sq_t                       sq_in_q;

  logic [cfp_pkg::OFF_W-1:0]          qx, qy;
  logic                               ofx, ofy, fcx, fcy;
  cfp_pkg::status_e                   st_d;

  always_comb begin
    qx  = {1'b0, dq.nq_x};
    qy  = {1'b0, dq.nq_y};
    ofx = (&offx_q[cfp_pkg::OFF_W-1:cfp_pkg::OUT_W-1]) ||
          !(|offx_q[cfp_pkg::OFF_W-1:cfp_pkg::OUT_W-1]);
    ofy = (&offy_q[cfp_pkg::OFF_W-1:cfp_pkg::OUT_W-1]) ||
          !(|offy_q[cfp_pkg::OFF_W-1:cfp_pkg::OUT_W-1]);
    fcx = (&ctrx_q[cfp_pkg::CTR_W-1:cfp_pkg::OUT_W-1]) ||
          !(|ctrx_q[cfp_pkg::CTR_W-1:cfp_pkg::OUT_W-1]);
    fcy = (&ctry_q[cfp_pkg::CTR_W-1:cfp_pkg::OUT_W-1]) ||
          !(|ctry_q[cfp_pkg::CTR_W-1:cfp_pkg::OUT_W-1]);
    if (collc_q) begin
      st_d = cfp_pkg::ST_COLLINEAR;
    end else if (!fitx_q || !fity_q || !fcx || !fcy) begin
      st_d = cfp_pkg::ST_RANGE;
    end else begin
      st_d = cfp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else if (en) begin
      bv_q <= {bv_q[BACK-2:0], div_v[cfp_pkg::DIV_STEPS]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      offx_q  <= dq.neg_x ? -$signed(qx) : $signed(qx);
      offy_q  <= dq.neg_y ? -$signed(qy) : $signed(qy);
      collb_q <= dq.coll;
      axb_q   <= dq.ax;
      ayb_q   <= dq.ay;

      fitx_q  <= ofx;
      fity_q  <= ofy;
      // The low offset bits are taken as signed so the center sum sign-extends.
      ctrx_q  <= cfp_pkg::CTR_W'($signed(offx_q[cfp_pkg::OUT_W-1:0]))
                 + cfp_pkg::CTR_W'(axb_q);
      ctry_q  <= cfp_pkg::CTR_W'($signed(offy_q[cfp_pkg::OUT_W-1:0]))
                 + cfp_pkg::CTR_W'(ayb_q);
      magx_q  <= offx_q[cfp_pkg::OUT_W-1] ? cfp_pkg::OUT_W'(-offx_q[cfp_pkg::OUT_W-1:0])
                                          : offx_q[cfp_pkg::OUT_W-1:0];
      magy_q  <= offy_q[cfp_pkg::OUT_W-1] ? cfp_pkg::OUT_W'(-offy_q[cfp_pkg::OUT_W-1:0])
                                          : offy_q[cfp_pkg::OUT_W-1:0];
      collc_q <= collb_q;

      st_q    <= st_d;
      cx_q    <= (st_d == cfp_pkg::ST_OK) ? ctrx_q[cfp_pkg::OUT_W-1:0] : '0;
      cy_q    <= (st_d == cfp_pkg::ST_OK) ? ctry_q[cfp_pkg::OUT_W-1:0] : '0;
      r2x_q   <= cfp_pkg::R2_W'(magx_q) * cfp_pkg::R2_W'(magx_q);
      r2y_q   <= cfp_pkg::R2_W'(magy_q) * cfp_pkg::R2_W'(magy_q);

      sq_in_q.n      <= (st_q == cfp_pkg::ST_OK) ? r2x_q + r2y_q : '0;
      sq_in_q.root   <= '0;
      sq_in_q.status <= st_q;
      sq_in_q.cx     <= cx_q;
      sq_in_q.cy     <= cy_q;
    end
  end

  // Square-root chain: one root bit per cell, weights 4^31 down to 4^0.
  logic         sq_v [cfp_pkg::SQRT_STEPS+1];
  cfp_pkg::sq_t sq_d [cfp_pkg::SQRT_STEPS+1];

  assign sq_v[0] = bv_q[BACK-1];
  assign sq_d[0] = sq_in_q;

  for (genvar i = 0; i < cfp_pkg::SQRT_STEPS; i++) begin : g_sqrt
    cfp_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .wt_i    (cfp_pkg::R2_W'(1) << (2 * (cfp_pkg::SQRT_STEPS - 1 - i))),
      .valid_i (sq_v[i]),
      .data_i  (sq_d[i]),
      .valid_o (sq_v[i+1]),
      .data_o  (sq_d[i+1])
    );
  end

  // Result leaving the last square-root cell.
  logic          last_v;
  cfp_pkg::res_t last_r;

  always_comb begin
    last_v        = sq_v[cfp_pkg::SQRT_STEPS] && en;
    last_r.status = sq_d[cfp_pkg::SQRT_STEPS].status;
    last_r.cx     = sq_d[cfp_pkg::SQRT_STEPS].cx;
    last_r.cy     = sq_d[cfp_pkg::SQRT_STEPS].cy;
    last_r.radius = sq_d[cfp_pkg::SQRT_STEPS].root[cfp_pkg::OUT_W-1:0];
  end

  // Output register and skid stage. The skid catches the one result that
  // the pipeline delivers while the output register waits on a stalled receiver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= last_v;
      end
    end else if (!out_valid_q) begin
      out_valid_q <= last_v;
    end else if (last_v) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (last_v) begin
        out_q <= last_r;
      end
    end else if (!out_valid_q) begin
      if (last_v) begin
        out_q <= last_r;
      end
    end else if (last_v) begin
      skid_q <= last_r;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign center_x_o  = out_q.cx;
  assign center_y_o  = out_q.cy;
  assign radius_o    = out_q.radius;

  // The skid stage only ever holds a result behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  // The skid stage fills only in a cycle where the output was stalled.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid stage filled without an output stall");

  // A result that is not a found circle carries a zero center and radius.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != cfp_pkg::ST_OK) |->
      (out_q.cx == '0 && out_q.cy == '0 && out_q.radius == '0))
    else $error("non-circle result with nonzero center or radius");

endmodule
